[rtl/dda_pkg.sv]
`default_nettype none

package dda_pkg;

    // Grid and fixed-point formats
    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 8;

    // Accumulator: sign, COORD_BITS integer bits, FRAC_BITS fraction bits
    localparam int ACC_W      = COORD_BITS + 1 + FRAC_BITS;
    // Dividend / quotient register of the serial divider
    localparam int DIV_W      = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    // Rounding adder width
    localparam int RND_W      = ACC_W + 1;
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic [COORD_BITS:0] COORD_MAX = (COORD_BITS + 1)'((1 << COORD_BITS) - 1);

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_STEP = 3'b100
    } dda_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture a segment and present its start point
        logic div_step;    // one quotient bit for both axes
        logic point_step;  // advance the accumulators and present a point
    } dda_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic zero_len;    // segment on the input ports has zero length
        logic div_done;    // increments are ready
        logic last_step;   // next point is the final one
    } dda_status_t;

endpackage

`default_nettype wire

[rtl/dda_ctrl.sv]
`default_nettype none

module dda_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire dda_pkg::dda_status_t status,
    output dda_pkg::dda_cmd_t         cmd
);
    import dda_pkg::*;

    dda_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // Output slot can take a new point when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Sequence one segment: capture, divide, emit points
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cmd.load   = 1'b1;
                    state_next = status.zero_len ? S_IDLE : S_DIV;
                end
            end
            S_DIV: begin
                if (status.div_done) begin
                    state_next = S_STEP;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_STEP: begin
                if (out_free) begin
                    cmd.point_step = 1'b1;
                    if (status.last_step) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the output valid until its transfer
    always_comb begin
        if (cmd.load || cmd.point_step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dda_dp.sv]
`default_nettype none

module dda_dp (
    input  wire logic                         aclk,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_x_start,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_y_start,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_x_end,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_y_end,
    input  wire dda_pkg::dda_cmd_t            cmd,
    output dda_pkg::dda_status_t              status,
    output logic [dda_pkg::COORD_BITS-1:0]    m_x_pixel,
    output logic [dda_pkg::COORD_BITS-1:0]    m_y_pixel,
    output logic                              m_last_point
);
    import dda_pkg::*;

    // Round half up and clamp a fixed-point position to the grid
    function automatic logic [COORD_BITS-1:0] round_pixel(input logic [ACC_W-1:0] acc);
        logic [RND_W-1:0]    r;
        logic [COORD_BITS:0] whole;
        r     = {acc[ACC_W-1], acc} + RND_HALF;
        whole = r[ACC_W-1:FRAC_BITS];
        if (r[RND_W-1]) begin
            return '0;
        end else if (whole > COORD_MAX) begin
            return COORD_MAX[COORD_BITS-1:0];
        end else begin
            return whole[COORD_BITS-1:0];
        end
    endfunction

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS-1:0]      mag_x, mag_y, steps_in;

    logic                  x_neg_reg, y_neg_reg;
    logic [COORD_BITS-1:0] steps_reg;
    logic [DIV_W-1:0]      xdiv_reg, ydiv_reg, xdiv_next, ydiv_next;
    logic [COORD_BITS-1:0] xrem_reg, yrem_reg, xrem_next, yrem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [COORD_BITS-1:0] cnt_reg;
    logic [ACC_W-1:0]      xacc_reg, yacc_reg, xacc_next, yacc_next;
    logic [ACC_W-1:0]      xinc, yinc;
    logic [COORD_BITS:0]   xtrial, ytrial;
    logic                  xge, yge;
    logic [COORD_BITS-1:0] x_pixel_reg, y_pixel_reg;
    logic                  last_reg;

    // Deltas, magnitudes and step count of the segment on the ports
    assign dx       = $signed({1'b0, s_x_end}) - $signed({1'b0, s_x_start});
    assign dy       = $signed({1'b0, s_y_end}) - $signed({1'b0, s_y_start});
    assign mag_x    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign mag_y    = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign steps_in = (mag_x > mag_y) ? mag_x : mag_y;

    // One restoring division step per axis
    assign xtrial    = {xrem_reg, xdiv_reg[DIV_W-1]};
    assign ytrial    = {yrem_reg, ydiv_reg[DIV_W-1]};
    assign xge       = xtrial >= {1'b0, steps_reg};
    assign yge       = ytrial >= {1'b0, steps_reg};
    assign xrem_next = xge ? COORD_BITS'(xtrial - {1'b0, steps_reg}) : xtrial[COORD_BITS-1:0];
    assign yrem_next = yge ? COORD_BITS'(ytrial - {1'b0, steps_reg}) : ytrial[COORD_BITS-1:0];
    assign xdiv_next = {xdiv_reg[DIV_W-2:0], xge};
    assign ydiv_next = {ydiv_reg[DIV_W-2:0], yge};

    // Signed increments from the finished quotients
    assign xinc = x_neg_reg ? ACC_W'(-{1'b0, xdiv_reg}) : {1'b0, xdiv_reg};
    assign yinc = y_neg_reg ? ACC_W'(-{1'b0, ydiv_reg}) : {1'b0, ydiv_reg};
    assign xacc_next = xacc_reg + xinc;
    assign yacc_next = yacc_reg + yinc;

    // Status to the controller
    assign status.zero_len  = (steps_in == '0);
    assign status.div_done  = (div_cnt_reg == '0);
    assign status.last_step = (cnt_reg == COORD_BITS'(1));

    assign m_x_pixel    = x_pixel_reg;
    assign m_y_pixel    = y_pixel_reg;
    assign m_last_point = last_reg;

    // Capture, divide, accumulate
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_neg_reg   <= dx[COORD_BITS];
            y_neg_reg   <= dy[COORD_BITS];
            steps_reg   <= steps_in;
            xdiv_reg    <= {mag_x, {FRAC_BITS{1'b0}}};
            ydiv_reg    <= {mag_y, {FRAC_BITS{1'b0}}};
            xrem_reg    <= '0;
            yrem_reg    <= '0;
            div_cnt_reg <= DIV_CNT_W'(DIV_W);
            cnt_reg     <= steps_in;
            xacc_reg    <= {1'b0, s_x_start, {FRAC_BITS{1'b0}}};
            yacc_reg    <= {1'b0, s_y_start, {FRAC_BITS{1'b0}}};
            x_pixel_reg <= s_x_start;
            y_pixel_reg <= s_y_start;
            last_reg    <= (steps_in == '0);
        end else if (cmd.div_step) begin
            xdiv_reg    <= xdiv_next;
            ydiv_reg    <= ydiv_next;
            xrem_reg    <= xrem_next;
            yrem_reg    <= yrem_next;
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end else if (cmd.point_step) begin
            xacc_reg    <= xacc_next;
            yacc_reg    <= yacc_next;
            cnt_reg     <= cnt_reg - COORD_BITS'(1);
            x_pixel_reg <= round_pixel(xacc_next);
            y_pixel_reg <= round_pixel(yacc_next);
            last_reg    <= (cnt_reg == COORD_BITS'(1));
        end
    end

endmodule

`default_nettype wire

[rtl/dda_line_rasterizer.sv]
`default_nettype none

// DDA line rasterizer for a 64 by 64 pixel grid. Each input transfer is one
// segment (start and end pixel); the block returns the start point and then
// one point per step, where the step count is the larger of |dx| and |dy|,
// and flags the final point with m_last_point. A zero-length segment returns
// only its start point. Per-step increments are signed fixed point with 8
// fraction bits, truncated toward zero, and each point is the accumulated
// position rounded half up. The start point is in the output register right
// after the input transfer; the increments then come from a bit-serial
// divider per axis (14 quotient bits, one per cycle for both axes, then a
// hand-off state), after which points follow at one per cycle while
// m_ready is high. The next segment is taken at the edge where the final
// point is transferred out.

module dda_line_rasterizer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_x_start,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_y_start,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_x_end,
    input  wire logic [dda_pkg::COORD_BITS-1:0] s_y_end,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [dda_pkg::COORD_BITS-1:0]      m_x_pixel,
    output logic [dda_pkg::COORD_BITS-1:0]      m_y_pixel,
    output logic                                m_last_point
);
    import dda_pkg::*;

    dda_cmd_t    cmd;
    dda_status_t status;

    // Sequencer
    dda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Divider, accumulators and output register
    dda_dp u_dp (
        .aclk         (aclk),
        .s_x_start    (s_x_start),
        .s_y_start    (s_y_start),
        .s_x_end      (s_x_end),
        .s_y_end      (s_y_end),
        .cmd          (cmd),
        .status       (status),
        .m_x_pixel    (m_x_pixel),
        .m_y_pixel    (m_y_pixel),
        .m_last_point (m_last_point)
    );

endmodule

`default_nettype wire

[dv/tb_dda_line_rasterizer.sv]
`timescale 1ns / 100ps

module tb_dda_line_rasterizer;
    import dda_pkg::*;

    localparam int GRID_MAX      = (1 << COORD_BITS) - 1;
    localparam int FIX_ONE       = 1 << FRAC_BITS;
    localparam int FIX_HALF      = 1 << (FRAC_BITS - 1);
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_SQUARE
    } rx_mode_t;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_x_start = '0;
    coord_t s_y_start = '0;
    coord_t s_x_end   = '0;
    coord_t s_y_end   = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_x_pixel;
    coord_t m_y_pixel;
    logic   m_last_point;

    pixel_t   pending_points[$];
    int       error_count    = 0;
    int       points_checked = 0;
    int       segments_sent  = 0;
    int       zero_len_sent  = 0;
    int       longest_steps  = 0;
    int       burst_left     = 0;
    bit       gaps_enabled   = 1'b1;
    int       cycle_count    = 0;
    rx_mode_t rx_mode        = RX_OPEN;
    int       rx_phase       = 0;

    dda_line_rasterizer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_x_start    (s_x_start),
        .s_y_start    (s_y_start),
        .s_x_end      (s_x_end),
        .s_y_end      (s_y_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_x_pixel    (m_x_pixel),
        .m_y_pixel    (m_y_pixel),
        .m_last_point (m_last_point)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Round a fixed-point position half up and clamp it to the grid
    function automatic coord_t round_to_pixel(input int acc);
        int r;
        r = acc + FIX_HALF;
        if (r < 0) begin
            r = 0;
        end
        r = r / FIX_ONE;
        if (r > GRID_MAX) begin
            r = GRID_MAX;
        end
        return coord_t'(r);
    endfunction

    // Walk the segment with DDA increments and queue every plotted point
    function automatic void plot_segment(input coord_t xs, input coord_t ys,
                                         input coord_t xe, input coord_t ye);
        int dx;
        int dy;
        int steps;
        int xacc;
        int yacc;
        int xinc;
        int yinc;
        dx    = int'(xe) - int'(xs);
        dy    = int'(ye) - int'(ys);
        steps = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > steps) begin
            steps = (dy < 0) ? -dy : dy;
        end
        pending_points.push_back('{x: xs, y: ys, last: (steps == 0)});
        if (steps == 0) begin
            zero_len_sent++;
            return;
        end
        if (steps > longest_steps) begin
            longest_steps = steps;
        end
        xacc = int'(xs) * FIX_ONE;
        yacc = int'(ys) * FIX_ONE;
        // signed division truncates toward zero
        xinc = (dx * FIX_ONE) / steps;
        yinc = (dy * FIX_ONE) / steps;
        for (int k = 1; k <= steps; k++) begin
            xacc += xinc;
            yacc += yinc;
            pending_points.push_back('{x: round_to_pixel(xacc),
                                       y: round_to_pixel(yacc),
                                       last: (k == steps)});
        end
    endfunction

    // Offer one segment; idle between bursts, predict on transfer
    task automatic send_segment(input coord_t xs, input coord_t ys,
                                input coord_t xe, input coord_t ye);
        int gap;
        if (gaps_enabled && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                              : $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        s_valid   <= 1'b1;
        s_x_start <= xs;
        s_y_start <= ys;
        s_x_end   <= xe;
        s_y_end   <= ye;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        plot_segment(xs, ys, xe, ye);
        segments_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Hold off the sender until every queued point has been seen
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_points.size() != 0) @(posedge aclk);
    endtask

    function automatic coord_t random_coord();
        return coord_t'($urandom_range(0, GRID_MAX));
    endfunction

    function automatic coord_t near_coord(input coord_t c);
        int v;
        v = int'(c) + $urandom_range(0, 12) - 6;
        if (v < 0) begin
            v = 0;
        end
        if (v > GRID_MAX) begin
            v = GRID_MAX;
        end
        return coord_t'(v);
    endfunction

    // Grid corners, edges, diagonals, single steps, rounding on thirds
    task automatic test_corner_segments();
        int seg [19][4];
        seg = '{
            '{0, 0, 0, 0},     '{63, 63, 63, 63}, '{0, 0, 63, 0},
            '{63, 0, 0, 0},    '{0, 0, 0, 63},    '{0, 63, 0, 0},
            '{0, 0, 63, 63},   '{63, 63, 0, 0},   '{0, 63, 63, 0},
            '{63, 0, 0, 63},   '{0, 0, 63, 1},    '{0, 0, 1, 63},
            '{10, 20, 13, 21}, '{13, 21, 10, 20}, '{5, 5, 6, 5},
            '{32, 32, 31, 33}, '{0, 0, 63, 62},   '{21, 42, 42, 21},
            '{42, 21, 21, 42}
        };
        foreach (seg[i]) begin
            send_segment(coord_t'(seg[i][0]), coord_t'(seg[i][1]),
                         coord_t'(seg[i][2]), coord_t'(seg[i][3]));
        end
    endtask

    // Let the block go fully idle a few times, then restart it
    task automatic test_pause_until_drained();
        coord_t xs;
        coord_t ys;
        for (int round = 0; round < 3; round++) begin
            repeat (3) begin
                xs = random_coord();
                ys = random_coord();
                send_segment(xs, ys, near_coord(xs), near_coord(ys));
            end
            wait_for_drain();
        end
    endtask

    // Mostly short segments, some full-range, zero-length and edge-to-edge
    task automatic test_random_segments(input int count);
        int     pick;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
        for (int i = 0; i < count; i++) begin
            // back-to-back stretch with no sender gaps
            gaps_enabled = !(i >= count / 3 && i < count / 2);
            pick = $urandom_range(0, 99);
            xs   = random_coord();
            ys   = random_coord();
            if (pick < 55) begin
                xe = near_coord(xs);
                ye = near_coord(ys);
            end else if (pick < 80) begin
                xe = random_coord();
                ye = random_coord();
            end else if (pick < 90) begin
                xe = xs;
                ye = ys;
            end else begin
                xs = $urandom_range(0, 1) ? coord_t'(GRID_MAX) : '0;
                ys = $urandom_range(0, 1) ? coord_t'(GRID_MAX) : '0;
                xe = ~xs;
                ye = random_coord();
            end
            send_segment(xs, ys, xe, ye);
        end
        gaps_enabled = 1'b1;
    endtask

    // Receiver stall pattern: switch among several modes every so often
    always @(posedge aclk) begin
        if (rx_phase == 0) begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 3));
            rx_phase <= $urandom_range(20, 120);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= $urandom_range(0, 1);
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) != 0);
            default:   m_ready <= rx_phase[2];
        endcase
    end

    // Compare each result transfer against the oldest queued point
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $error("point (%0d,%0d) last=%0d arrived with nothing pending",
                       m_x_pixel, m_y_pixel, m_last_point);
                error_count++;
            end else begin
                want = pending_points.pop_front();
                points_checked++;
                if (m_x_pixel !== want.x) begin
                    $error("x_pixel mismatch: expected %0d, actual %0d",
                           want.x, m_x_pixel);
                    error_count++;
                end
                if (m_y_pixel !== want.y) begin
                    $error("y_pixel mismatch: expected %0d, actual %0d",
                           want.y, m_y_pixel);
                    error_count++;
                end
                if (m_last_point !== want.last) begin
                    $error("last_point mismatch: expected %0d, actual %0d",
                           want.last, m_last_point);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points still pending",
                     cycle_count, pending_points.size());
            $display("dda_line_rasterizer verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_segments();
        test_pause_until_drained();
        test_random_segments(150);

        // drain, then allow any stray output to show up
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Rasterized %0d segments (%0d zero-length, longest %0d steps),",
                 segments_sent, zero_len_sent, longest_steps);
        $display("checked %0d plotted points under random sender gaps and stalls.",
                 points_checked);
        if (error_count == 0) begin
            $display("dda_line_rasterizer verification clean");
        end else begin
            $display("dda_line_rasterizer verification failed");
        end
        $finish;
    end

endmodule
